// ----- sv/centered_integer_upscale_blit_defines.svh -----
// Assertion macros shared by the upscale blit RTL.
`ifndef CENTERED_INTEGER_UPSCALE_BLIT_DEFINES_SVH
`define CENTERED_INTEGER_UPSCALE_BLIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The condition holds in the same cycle as the trigger.
`define CIUB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition holds in the cycle after the trigger.
`define CIUB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CIUB_ASSERT_SAME(label, ante, cons, msg)
`define CIUB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/ciub_pkg.sv -----
// Types, constants and helper functions of the upscale blit.
package ciub_pkg;

    // Scale limit and default source store size.
    localparam int MAX_SCALE           = 5;
    localparam int IMAGE_WORDS_DEFAULT = 524288;

    // Field widths.
    localparam int SW_W    = 13;
    localparam int SH_W    = 13;
    localparam int IW_W    = 11;
    localparam int IH_W    = 10;
    localparam int IDX_W   = 19;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int SCALE_W = 3;

    // Derived widths of the geometry and address path.
    localparam int PROD_W  = 14;  // scale times image size
    localparam int GEO_W   = 16;  // signed offsets and bounds
    localparam int DIFF_W  = 14;  // distance into the drawn area
    localparam int SI_W    = IH_W + IW_W + 1;

    // Configuration port.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Cycles the geometry pipeline needs after a configuration change.
    localparam int GEO_LATENCY = 3;
    localparam int SETTLE_W    = 2;

    // Reciprocal multiply used to divide by the scale.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 19;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_IMAGE_WIDTH   = 2'd2,
        CFG_IMAGE_HEIGHT  = 2'd3
    } cfg_sel_t;

    // Command and status codes.
    localparam logic CMD_LOAD       = 1'b0;
    localparam logic CMD_QUERY      = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOT_FIT = 1'b1;

    // Query sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ,
        S_RESP
    } state_t;

    // One input item.
    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   pixel_index;
        logic [PIX_W-1:0]   pixel_value;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } request_t;

    // One result item.
    typedef struct packed {
        logic               status;
        logic               write_enable;
        logic [PIX_W-1:0]   dest_value;
        logic [SCALE_W-1:0] scale;
    } result_t;

    // Rounded-up 2^RECIP_SHIFT / scale; exact for the distances that occur.
    function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            3'd1:    r = 19'd262144;
            3'd2:    r = 19'd131072;
            3'd3:    r = 19'd87382;
            3'd4:    r = 19'd65536;
            3'd5:    r = 19'd52429;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/centered_integer_upscale_blit.sv -----
// Centered nearest-neighbor integer upscale blit: source store, geometry and query path.
//
// A load item writes one source byte, when its index lies inside the store, and returns
// its result in the cycle after it is taken; a query item returns its result after the
// registered chain of scale division, source address multiply and memory read, and busy
// stays high until the result is out. After reset and after every configuration write
// the scale and placement settle through a three-stage pipeline, with busy high until it
// has settled. Each result appears on response for one cycle with done high and must be
// taken then. The source store comes up undefined: query only pixels that were loaded.

`include "centered_integer_upscale_blit_defines.svh"

module centered_integer_upscale_blit #(
    parameter int IMAGE_WORDS = ciub_pkg::IMAGE_WORDS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ciub_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ciub_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             start,
    input  ciub_pkg::request_t               request,
    output logic                             busy,
    output logic                             done,
    output ciub_pkg::result_t                response
);

    localparam int AW = $clog2(IMAGE_WORDS);

    // Configuration registers.
    logic [ciub_pkg::SW_W-1:0] sw_reg;
    logic [ciub_pkg::SH_W-1:0] sh_reg;
    logic [ciub_pkg::IW_W-1:0] iw_reg;
    logic [ciub_pkg::IH_W-1:0] ih_reg;

    // Geometry pipeline.
    logic [ciub_pkg::PROD_W-1:0]        wk_reg [1:ciub_pkg::MAX_SCALE];
    logic [ciub_pkg::PROD_W-1:0]        hk_reg [1:ciub_pkg::MAX_SCALE];
    logic [ciub_pkg::SCALE_W-1:0]       scale_reg, scale_next;
    logic [ciub_pkg::PROD_W-1:0]        mw_reg, mw_next;
    logic [ciub_pkg::PROD_W-1:0]        mh_reg, mh_next;
    logic signed [ciub_pkg::GEO_W-1:0]  spx_reg, spy_reg;
    logic signed [ciub_pkg::GEO_W-1:0]  x0_reg, x1_reg, y0_reg, y1_reg, band_hi_reg;
    logic signed [ciub_pkg::GEO_W-1:0]  spx_next, spy_next;
    logic signed [ciub_pkg::GEO_W-1:0]  x1_next, y1_next;
    logic [ciub_pkg::SETTLE_W-1:0]      settle_reg, settle_next;

    // Query path.
    ciub_pkg::state_t                   state_reg, state_next;
    logic                               draw_reg, band_reg;
    logic [ciub_pkg::DIFF_W-1:0]        dx_reg, dy_reg;
    logic [ciub_pkg::IW_W-1:0]          col_reg;
    logic [ciub_pkg::IH_W-1:0]          row_reg;
    logic [ciub_pkg::SI_W-1:0]          si_reg;
    logic                               si_ok_reg;
    logic [ciub_pkg::PIX_W-1:0]         mem_q_reg;
    logic                               done_reg, done_next;
    ciub_pkg::result_t                  result_reg, result_next;

    // Decoded query geometry.
    logic                               accept, accept_query, accept_load;
    logic signed [ciub_pkg::GEO_W-1:0]  qx, qy, dx_full, dy_full;
    logic                               in_draw, in_band;
    logic [ciub_pkg::RECIP_W-1:0]       rcp;
    logic [ciub_pkg::DIFF_W+ciub_pkg::RECIP_W-1:0] prod_x, prod_y;
    logic [ciub_pkg::SI_W-1:0]          si_next;
    logic                               load_ok;
    logic [31:0]                        load_addr;

    // Source store.
    logic [ciub_pkg::PIX_W-1:0]         mem [IMAGE_WORDS];
    logic                               rd_en;

    // Handshake.
    assign accept       = start && !busy;
    assign accept_query = accept && (request.cmd == ciub_pkg::CMD_QUERY);
    assign accept_load  = accept && (request.cmd == ciub_pkg::CMD_LOAD);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 13'd640;
            sh_reg <= 13'd480;
            iw_reg <= 11'd640;
            ih_reg <= 10'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ciub_pkg::CFG_SCREEN_WIDTH:  sw_reg <= cfg_data[ciub_pkg::SW_W-1:0];
                ciub_pkg::CFG_SCREEN_HEIGHT: sh_reg <= cfg_data[ciub_pkg::SH_W-1:0];
                ciub_pkg::CFG_IMAGE_WIDTH:   iw_reg <= cfg_data[ciub_pkg::IW_W-1:0];
                ciub_pkg::CFG_IMAGE_HEIGHT:  ih_reg <= cfg_data[ciub_pkg::IH_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Settle counter: the geometry is trusted once it has run its full latency.
    always_comb
    begin
        if (cfg_we)
            settle_next = ciub_pkg::SETTLE_W'(ciub_pkg::GEO_LATENCY);
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
        else
            settle_next = settle_reg;
    end

    // Geometry stage one: multiples of the image size.
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= ciub_pkg::MAX_SCALE; k++)
        begin
            wk_reg[k] <= ciub_pkg::PROD_W'(iw_reg) * ciub_pkg::PROD_W'(k);
            hk_reg[k] <= ciub_pkg::PROD_W'(ih_reg) * ciub_pkg::PROD_W'(k);
        end
    end

    // Geometry stage two: largest multiple where both sides fit; 1 if only width fits.
    always_comb
    begin
        logic run;
        logic [ciub_pkg::SCALE_W-1:0] cnt;
        run = 1'b1;
        cnt = '0;
        for (int k = 1; k <= ciub_pkg::MAX_SCALE; k++)
        begin
            if (run && wk_reg[k] <= ciub_pkg::PROD_W'(sw_reg)
                    && hk_reg[k] <= ciub_pkg::PROD_W'(sh_reg))
                cnt = ciub_pkg::SCALE_W'(k);
            else
                run = 1'b0;
        end
        if (cnt == '0)
            scale_next = (wk_reg[1] > ciub_pkg::PROD_W'(sw_reg)) ? '0 : 3'd1;
        else
            scale_next = cnt;
        mw_next = '0;
        mh_next = '0;
        for (int k = 1; k <= ciub_pkg::MAX_SCALE; k++)
        begin
            if (scale_next == ciub_pkg::SCALE_W'(k))
            begin
                mw_next = wk_reg[k];
                mh_next = hk_reg[k];
            end
        end
    end

    // Geometry stage three: centered placement and clipped bounds.
    // The offsets are halved with an arithmetic shift, so they round down.
    always_comb
    begin
        spx_next = $signed(ciub_pkg::GEO_W'(sw_reg) - ciub_pkg::GEO_W'(mw_reg)) >>> 1;
        spy_next = $signed(ciub_pkg::GEO_W'(sh_reg) - ciub_pkg::GEO_W'(mh_reg)) >>> 1;
        x1_next  = spx_next + ciub_pkg::GEO_W'(mw_reg);
        y1_next  = spy_next + ciub_pkg::GEO_W'(mh_reg);
        if (x1_next > ciub_pkg::GEO_W'(sw_reg))
            x1_next = ciub_pkg::GEO_W'(sw_reg);
        if (y1_next > ciub_pkg::GEO_W'(sh_reg))
            y1_next = ciub_pkg::GEO_W'(sh_reg);
    end

    always_ff @(posedge clk)
    begin
        scale_reg   <= scale_next;
        mw_reg      <= mw_next;
        mh_reg      <= mh_next;
        spx_reg     <= spx_next;
        spy_reg     <= spy_next;
        x0_reg      <= (spx_next > 0) ? spx_next : '0;
        y0_reg      <= (spy_next > 0) ? spy_next : '0;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        band_hi_reg <= ciub_pkg::GEO_W'(sh_reg) - spy_next;
    end

    // Query classification at accept.
    always_comb
    begin
        qx      = ciub_pkg::GEO_W'(request.dest_x);
        qy      = ciub_pkg::GEO_W'(request.dest_y);
        in_draw = (scale_reg != '0) && qx >= x0_reg && qx < x1_reg
                  && qy >= y0_reg && qy < y1_reg;
        in_band = (scale_reg != '0) && spy_reg > 0
                  && qx < ciub_pkg::GEO_W'(sw_reg) && qy < ciub_pkg::GEO_W'(sh_reg)
                  && (qy < spy_reg || qy >= band_hi_reg);
        dx_full = qx - spx_reg;
        dy_full = qy - spy_reg;
    end

    // Division by the scale through its reciprocal, and the source address.
    always_comb
    begin
        rcp    = ciub_pkg::recip(scale_reg);
        prod_x = (ciub_pkg::DIFF_W + ciub_pkg::RECIP_W)'(dx_reg)
                 * (ciub_pkg::DIFF_W + ciub_pkg::RECIP_W)'(rcp);
        prod_y = (ciub_pkg::DIFF_W + ciub_pkg::RECIP_W)'(dy_reg)
                 * (ciub_pkg::DIFF_W + ciub_pkg::RECIP_W)'(rcp);
        si_next = ciub_pkg::SI_W'(row_reg) * ciub_pkg::SI_W'(iw_reg)
                  + ciub_pkg::SI_W'(col_reg);
    end

    // Query datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept_query)
        begin
            draw_reg <= in_draw;
            band_reg <= in_band;
            dx_reg   <= dx_full[ciub_pkg::DIFF_W-1:0];
            dy_reg   <= dy_full[ciub_pkg::DIFF_W-1:0];
        end
        if (state_reg == ciub_pkg::S_DIV)
        begin
            col_reg <= prod_x[ciub_pkg::RECIP_SHIFT +: ciub_pkg::IW_W];
            row_reg <= prod_y[ciub_pkg::RECIP_SHIFT +: ciub_pkg::IH_W];
        end
        if (state_reg == ciub_pkg::S_ADDR)
            si_reg <= si_next;
        if (rd_en)
            si_ok_reg <= 32'(si_reg) < 32'(IMAGE_WORDS);
    end

    // Source store: one write port for loads, one registered read port.
    assign load_addr = 32'(request.pixel_index);
    assign load_ok   = load_addr < 32'(IMAGE_WORDS);

    always_ff @(posedge clk)
    begin
        if (accept_load && load_ok)
            mem[load_addr[AW-1:0]] <= request.pixel_value;
        if (rd_en)
            mem_q_reg <= mem[si_reg[AW-1:0]];
    end

    // Sequencer next state.
    always_comb
    begin
        case (state_reg)
            ciub_pkg::S_IDLE: state_next = accept_query ? ciub_pkg::S_DIV : ciub_pkg::S_IDLE;
            ciub_pkg::S_DIV:  state_next = ciub_pkg::S_ADDR;
            ciub_pkg::S_ADDR: state_next = ciub_pkg::S_READ;
            ciub_pkg::S_READ: state_next = ciub_pkg::S_RESP;
            ciub_pkg::S_RESP: state_next = ciub_pkg::S_IDLE;
            default:          state_next = ciub_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy  = (state_reg != ciub_pkg::S_IDLE) || (settle_reg != '0);
        rd_en = (state_reg == ciub_pkg::S_READ);
    end

    // Result register: loads answer at once, queries after the read.
    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        if (accept_load)
        begin
            done_next                = 1'b1;
            result_next.status       = (scale_reg == '0) ? ciub_pkg::STATUS_NOT_FIT
                                                         : ciub_pkg::STATUS_OK;
            result_next.write_enable = 1'b0;
            result_next.dest_value   = '0;
            result_next.scale        = scale_reg;
        end
        else if (state_reg == ciub_pkg::S_RESP)
        begin
            done_next                = 1'b1;
            result_next.status       = (scale_reg == '0) ? ciub_pkg::STATUS_NOT_FIT
                                                         : ciub_pkg::STATUS_OK;
            result_next.write_enable = draw_reg || band_reg;
            result_next.dest_value   = (draw_reg && si_ok_reg) ? mem_q_reg : '0;
            result_next.scale        = scale_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ciub_pkg::S_IDLE;
            settle_reg <= ciub_pkg::SETTLE_W'(ciub_pkg::GEO_LATENCY);
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
            done_reg   <= done_next;
        end
    end

    assign done     = done_reg;
    assign response = result_reg;

    // Checks on the sequencer and the result.
    `CIUB_ASSERT_SAME(a_done_idle, done, state_reg == ciub_pkg::S_IDLE,
        "result while query in flight")
    `CIUB_ASSERT_NEXT(a_query_start, accept_query, state_reg == ciub_pkg::S_DIV,
        "query not started")
    `CIUB_ASSERT_NEXT(a_resp_done, state_reg == ciub_pkg::S_RESP, done,
        "query result missing")
    `CIUB_ASSERT_SAME(a_no_fit, done && response.scale == '0,
        !response.write_enable && response.status == ciub_pkg::STATUS_NOT_FIT,
        "write without a scale")
    `CIUB_ASSERT_SAME(a_scale_max, done, response.scale <= 3'(ciub_pkg::MAX_SCALE),
        "scale above limit")

endmodule
